// ----- hw/rtl/casp_pkg.sv -----
// Shared constants for the cellular automaton smoothing pass block.
package casp_pkg;

   // configuration channel
   localparam int CsrIndexW = 8;
   localparam int CsrDataW  = 11;
   localparam int ThreshW   = 4;

   localparam logic [CsrIndexW-1:0] CsrMapWidth  = 8'd0;
   localparam logic [CsrIndexW-1:0] CsrMapHeight = 8'd1;
   localparam logic [CsrIndexW-1:0] CsrThreshold = 8'd2;

   // reset values of the registers
   localparam int RstMapWidth  = 256;
   localparam int RstMapHeight = 256;
   localparam logic [ThreshW-1:0] RstThreshold = 4'd5;

   // request beat: cell_solid in bit 0, padded to a byte
   localparam int ReqDataW = 8;

   // three rotating line buffers
   localparam int NumLines = 3;

endpackage

// ----- hw/rtl/cellular_automaton_smoothing_pass_top.sv -----
// Top level of the cellular automaton smoothing pass: line buffers, window and result queue.
// A request beat is registered into the window stage, and its results are loaded from there
// into the result queue. Throughput: one cell per cycle while the queue keeps up; a cell with
// two or three results stalls requests while the queue drains, one beat a cycle with rsp_tready.
// Reset (synchronous, active high): counters and the result queue clear, registers go to 256/256/5;
// line buffers are not cleared and hold whatever they last held.
module cellular_automaton_smoothing_pass_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // request stream
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [casp_pkg::ReqDataW-1:0]                 req_tdata,  // [0] cell_solid
   // result stream
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // out_row, out_col, out_solid from bit 0 up, zero padded to whole bytes
   output logic [(($clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)+1+7)/8)*8-1:0] rsp_tdata,
   output logic                                          rsp_tlast,  // run_last
   // register writes
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [casp_pkg::CsrIndexW-1:0]                csr_index,
   input  logic [casp_pkg::CsrDataW-1:0]                 csr_wdata
);

   localparam int ColW     = $clog2(MAX_WIDTH);
   localparam int RowW     = $clog2(MAX_HEIGHT);
   localparam int RstWLast = (casp_pkg::RstMapWidth  > MAX_WIDTH  ? MAX_WIDTH
                                                                  : casp_pkg::RstMapWidth)  - 1;
   localparam int RstHLast = (casp_pkg::RstMapHeight > MAX_HEIGHT ? MAX_HEIGHT
                                                                  : casp_pkg::RstMapHeight) - 1;

   // size register value to last index, saturated to 1..max_size
   function automatic int size_to_last(input logic [casp_pkg::CsrDataW-1:0] raw,
                                       input int max_size);
      int v;
      v = int'(raw);
      if (v < 1) v = 1;
      if (v > max_size) v = max_size;
      return v - 1;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [ColW-1:0]              wlast_ff;   // map_width - 1
   logic [RowW-1:0]              hlast_ff;   // map_height - 1
   logic [casp_pkg::ThreshW-1:0] thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff  <= ColW'(RstWLast);
         hlast_ff  <= RowW'(RstHLast);
         thresh_ff <= casp_pkg::RstThreshold;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            casp_pkg::CsrMapWidth:  wlast_ff  <= ColW'(size_to_last(csr_wdata, MAX_WIDTH));
            casp_pkg::CsrMapHeight: hlast_ff  <= RowW'(size_to_last(csr_wdata, MAX_HEIGHT));
            casp_pkg::CsrThreshold: thresh_ff <= csr_wdata[casp_pkg::ThreshW-1:0];
            default: ;  // unmapped index, beat dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- handshakes
   logic req_beat, rsp_beat;
   logic s1_valid_ff, s1_adv;
   logic [1:0] s1_n;
   logic [1:0] ob_cnt_ff, ob_idx_ff;
   logic ob_free;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // queue empties this cycle or already empty
   assign ob_free   = (ob_cnt_ff == 2'd0) || (rsp_beat && (ob_idx_ff == ob_cnt_ff - 2'd1));
   assign s1_adv    = s1_valid_ff && (ob_free || (s1_n == 2'd0));
   assign req_tready = !s1_valid_ff || s1_adv;

   // ---------------------------------------------------------------- raster position
   logic [ColW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic [1:0]      inc_sel_ff;  // which line buffer takes the incoming row
   logic            acc_end_col, acc_last_row;

   assign acc_end_col  = (col_ff >= wlast_ff);
   assign acc_last_row = (row_ff >= hlast_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         inc_sel_ff <= 2'd0;
      end else if (req_beat) begin
         if (acc_end_col) begin
            col_ff     <= '0;
            row_ff     <= acc_last_row ? '0 : row_ff + RowW'(1);
            inc_sel_ff <= (inc_sel_ff == 2'd2) ? 2'd0 : inc_sel_ff + 2'd1;
         end else begin
            col_ff <= col_ff + ColW'(1);
         end
      end
   end

   // ---------------------------------------------------------------- window stage
   logic            s1_x_ff, s1_end_col_ff, s1_last_row_ff;
   logic [ColW-1:0] s1_c_ff;
   logic [RowW-1:0] s1_r_ff;
   logic [1:0]      s1_inc_ff;
   logic [casp_pkg::NumLines-1:0] rd_ff;   // registered read of every line at the column

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_beat) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_x_ff        <= req_tdata[0];
         s1_c_ff        <= col_ff;
         s1_r_ff        <= row_ff;
         s1_end_col_ff  <= acc_end_col;
         s1_last_row_ff <= acc_last_row;
         s1_inc_ff      <= inc_sel_ff;
      end
   end

   logic [1:0] mid_sel, abv_sel;
   always_comb begin
      case (s1_inc_ff)
         2'd0:    begin mid_sel = 2'd2; abv_sel = 2'd1; end
         2'd1:    begin mid_sel = 2'd0; abv_sel = 2'd2; end
         default: begin mid_sel = 2'd1; abv_sel = 2'd0; end
      endcase
   end

   logic abv_rd, mid_rd;
   assign abv_rd = rd_ff[abv_sel];
   assign mid_rd = rd_ff[mid_sel];

   // 3x3 window columns c-2 and c-1; column c comes from the line reads and the beat
   logic a1_ff, a2_ff, m1_ff, m2_ff, i1_ff, i2_ff;

   // cell (r-1, c-1) is interior
   logic settle_en;
   assign settle_en = (s1_c_ff >= ColW'(2)) && ((s1_c_ff - ColW'(1)) < wlast_ff) &&
                      (s1_r_ff >= RowW'(2)) && ((s1_r_ff - RowW'(1)) < hlast_ff);

   logic [3:0] nsum;
   logic       settled;
   assign nsum = 4'(a2_ff) + 4'(a1_ff) + 4'(abv_rd) + 4'(m2_ff) + 4'(mid_rd)
               + 4'(i2_ff) + 4'(i1_ff) + 4'(s1_x_ff);
   assign settled = m1_ff | (settle_en && (nsum >= thresh_ff));

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         a2_ff <= a1_ff;
         a1_ff <= abv_rd;
         m2_ff <= settled;  // left neighbour counts with its updated value
         m1_ff <= mid_rd;
         i2_ff <= i1_ff;
         i1_ff <= s1_x_ff;
      end
   end

   // ---------------------------------------------------------------- line buffers
   for (genvar b = 0; b < casp_pkg::NumLines; b++) begin : g_line
      logic line_mem [MAX_WIDTH];
      logic we_acc, we_set;

      assign we_acc = req_beat && (inc_sel_ff == 2'(b));
      assign we_set = s1_adv && settle_en && (mid_sel == 2'(b));

      always_ff @(posedge clock) begin
         if (we_acc) begin
            line_mem[col_ff] <= req_tdata[0];
         end else if (we_set) begin
            line_mem[s1_c_ff - ColW'(1)] <= settled;
         end
         if (req_beat) begin
            rd_ff[b] <= line_mem[col_ff];
         end
      end
   end

   // ---------------------------------------------------------------- results
   logic e0, e1, e2;
   assign e0 = (s1_r_ff != '0) && (s1_c_ff != '0);  // (r-1, c-1) settled
   assign e1 = (s1_r_ff != '0) && s1_end_col_ff;     // (r-1, c) right border
   assign e2 = s1_last_row_ff;                        // (r, c) bottom row
   assign s1_n = 2'(e0) + 2'(e1) + 2'(e2);

   logic [RowW-1:0] res_row [3];
   logic [ColW-1:0] res_col [3];
   logic            res_sol [3];

   always_comb begin
      res_row[0] = s1_r_ff - RowW'(1); res_col[0] = s1_c_ff - ColW'(1); res_sol[0] = settled;
      res_row[1] = s1_r_ff - RowW'(1); res_col[1] = s1_c_ff;            res_sol[1] = mid_rd;
      res_row[2] = s1_r_ff;            res_col[2] = s1_c_ff;            res_sol[2] = s1_x_ff;
   end

   logic [RowW-1:0] ob_row_ff [3];
   logic [ColW-1:0] ob_col_ff [3];
   logic            ob_sol_ff [3];
   logic            ob_load;
   logic [1:0]      slot0, slot1;

   assign ob_load = s1_adv && (s1_n != 2'd0);
   assign slot0   = e0 ? 2'd0 : (e1 ? 2'd1 : 2'd2);
   assign slot1   = (e0 && e1) ? 2'd1 : 2'd2;

   always_ff @(posedge clock) begin
      if (ob_load) begin
         ob_row_ff[0] <= res_row[slot0]; ob_col_ff[0] <= res_col[slot0];
         ob_sol_ff[0] <= res_sol[slot0];
         ob_row_ff[1] <= res_row[slot1]; ob_col_ff[1] <= res_col[slot1];
         ob_sol_ff[1] <= res_sol[slot1];
         ob_row_ff[2] <= res_row[2];     ob_col_ff[2] <= res_col[2];
         ob_sol_ff[2] <= res_sol[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
         ob_idx_ff <= 2'd0;
      end else if (ob_load) begin
         ob_cnt_ff <= s1_n;
         ob_idx_ff <= 2'd0;
      end else if (rsp_beat) begin
         if (rsp_tlast) begin
            ob_cnt_ff <= 2'd0;
            ob_idx_ff <= 2'd0;
         end else begin
            ob_idx_ff <= ob_idx_ff + 2'd1;
         end
      end
   end

   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_tlast  = (ob_idx_ff == ob_cnt_ff - 2'd1);

   always_comb begin
      rsp_tdata                    = '0;
      rsp_tdata[RowW-1:0]          = ob_row_ff[ob_idx_ff];
      rsp_tdata[RowW +: ColW]      = ob_col_ff[ob_idx_ff];
      rsp_tdata[RowW + ColW]       = ob_sol_ff[ob_idx_ff];
   end

   // ---------------------------------------------------------------- checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ob_idx_ff < ob_cnt_ff))
      else $error("result queue index past its fill");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      ob_load |=> (ob_cnt_ff == $past(s1_n)) && (ob_idx_ff == 2'd0))
      else $error("result queue loaded with wrong count");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_beat && acc_end_col) |=> (col_ff == '0))
      else $error("column counter did not wrap at row end");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_tlast && !ob_load) |=> !rsp_tvalid)
      else $error("result queue not empty after last beat");

   a_inc_sel: assert property (@(posedge clock) disable iff (reset)
      (req_beat && !acc_end_col) |=> $stable(inc_sel_ff))
      else $error("line buffers rotated mid-row");

endmodule

// ----- sim/cellular_automaton_smoothing_pass_top_test.sv -----
// Self-checking testbench for the cellular automaton smoothing pass: streams maps, checks cells.
`timescale 1ns / 100ps

module cellular_automaton_smoothing_pass_top_test;

   localparam int MaxW     = 1024;
   localparam int MaxH     = 1024;
   localparam int RowW     = $clog2(MaxH);
   localparam int ColW     = $clog2(MaxW);
   localparam int RspDataW = ((RowW + ColW + 1 + 7) / 8) * 8;

   typedef logic [casp_pkg::CsrIndexW-1:0] csr_index_type;
   typedef logic [casp_pkg::CsrDataW-1:0]  csr_data_type;
   typedef logic [casp_pkg::ThreshW-1:0]   thresh_type;
   typedef logic [casp_pkg::ReqDataW-1:0]  req_data_type;

   // index that maps to no register; a write there must change nothing
   localparam csr_index_type CsrUnmapped = 8'd3;

   localparam int RandomCells   = 250;
   localparam int DrainCycles   = 8;     // beat to result via window stage and queue, plus slack
   localparam int TailCycles    = 20;
   localparam int HoldCycles    = 300;   // long receiver hold-off to back the block up
   localparam int WatchdogLimit = 2000;  // quiet cycles tolerated; longest legal lull is the hold
   localparam int MaxReports    = 40;

   typedef struct packed {
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      logic            solid;
      logic            last;
   } cell_result_type;

   // Predicts the smoothed cells and keeps the expected beats in arrival order.
   class smoothing_scoreboard_type;
      csr_data_type        reg_w, reg_h;
      thresh_type          reg_t;
      bit [MaxW-1:0]       above_line, middle_line, incoming_line;
      int unsigned         col_ctr, row_ctr;
      cell_result_type     expected_cells[$];
      int                  errors;

      function new();
         reg_w = csr_data_type'(casp_pkg::RstMapWidth);
         reg_h = csr_data_type'(casp_pkg::RstMapHeight);
         reg_t = casp_pkg::RstThreshold;
         above_line = '0;
         middle_line = '0;
         incoming_line = '0;
         col_ctr = 0;
         row_ctr = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction

      function void write_reg(csr_index_type idx, csr_data_type val);
         case (idx)
            casp_pkg::CsrMapWidth:  reg_w = val;
            casp_pkg::CsrMapHeight: reg_h = val;
            casp_pkg::CsrThreshold: reg_t = val[casp_pkg::ThreshW-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(csr_data_type v, int unsigned hi);
         if (v == 0) return 1;
         if (32'(v) > hi) return hi;
         return 32'(v);
      endfunction

      // final value of middle-row cell q; interior air with enough solid neighbours turns solid
      function bit settle_cell(int unsigned q, int unsigned p, int unsigned w, int unsigned h);
         bit          v;
         int unsigned n;
         v = middle_line[q];
         if (!v && p >= 1 && p + 2 <= h && q >= 1 && q + 2 <= w) begin
            n = $countones({above_line[q-1], above_line[q], above_line[q+1],
                            middle_line[q-1], middle_line[q+1],
                            incoming_line[q-1], incoming_line[q], incoming_line[q+1]});
            if (n >= 32'(reg_t)) v = 1'b1;
            middle_line[q] = v;
         end
         return v;
      endfunction

      function void push_cell(int unsigned r, int unsigned c, bit s);
         cell_result_type item;
         item.row   = RowW'(r);
         item.col   = ColW'(c);
         item.solid = s;
         item.last  = 1'b0;
         expected_cells.push_back(item);
      endfunction

      function void note_cell(bit x);
         int unsigned     w, h, c, r, n;
         bit              end_col, last_row;
         cell_result_type tail;
         w = clamp_size(reg_w, MaxW);
         h = clamp_size(reg_h, MaxH);
         c = (col_ctr >= MaxW) ? MaxW - 1 : col_ctr;
         r = row_ctr;
         end_col  = (c + 1 >= w);
         last_row = (r + 1 >= h);
         incoming_line[c] = x;
         n = 0;
         // cell up-left is final now; at row end the cell straight above as well
         if (r >= 1) begin
            if (c >= 1) begin
               push_cell(r - 1, c - 1, settle_cell(c - 1, r - 1, w, h));
               n++;
            end
            if (end_col) begin
               push_cell(r - 1, c, middle_line[c]);
               n++;
            end
         end
         // bottom row has nothing below it, so it leaves as it came
         if (last_row) begin
            push_cell(r, c, x);
            n++;
         end
         if (n > 0) begin
            tail = expected_cells.pop_back();
            tail.last = 1'b1;
            expected_cells.push_back(tail);
         end
         if (end_col) begin
            above_line  = middle_line;
            middle_line = incoming_line;
            col_ctr = 0;
            row_ctr = last_row ? 0 : r + 1;
         end else begin
            col_ctr = c + 1;
         end
      endfunction

      function void mismatch(string what, logic [ColW-1:0] want, logic [ColW-1:0] got);
         errors++;
         if (errors <= MaxReports)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      endfunction

      function void check_cell(logic [RspDataW-1:0] data, logic last);
         cell_result_type want, got;
         got.row   = data[RowW-1:0];
         got.col   = data[RowW+ColW-1:RowW];
         got.solid = data[RowW+ColW];
         got.last  = last;
         if (expected_cells.size() == 0) begin
            errors++;
            if (errors <= MaxReports)
               $display("%0t: expected no beat, got row %0d col %0d solid %b last %b",
                        $time, got.row, got.col, got.solid, got.last);
            return;
         end
         want = expected_cells.pop_front();
         if (got.row !== want.row)     mismatch("row", ColW'(want.row), ColW'(got.row));
         if (got.col !== want.col)     mismatch("col", want.col, got.col);
         if (got.solid !== want.solid) mismatch("solid", ColW'(want.solid), ColW'(got.solid));
         if (got.last !== want.last)   mismatch("last", ColW'(want.last), ColW'(got.last));
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   req_data_type             req_tdata;   // [0] cell_solid
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataW-1:0]      rsp_tdata;   // out_row, out_col, out_solid from bit 0 up
   logic                     rsp_tlast;   // run_last
   logic                     csr_valid;
   logic                     csr_ready;
   csr_index_type            csr_index;
   csr_data_type             csr_wdata;

   smoothing_scoreboard_type board;
   logic                want_hold;     // asks the receiver for its long hold-off
   bit                  req_steady;    // sender offers back to back when set
   int                  quiet_cycles = 0;

   cellular_automaton_smoothing_pass_top #(
      .MAX_WIDTH  (MaxW),
      .MAX_HEIGHT (MaxH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, the odd long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_run();
      if ($urandom_range(0, 4) != 0) return $urandom_range(1, 8);
      return $urandom_range(20, 150);
   endfunction

   // one cell beat; the predictor hears of it at the edge that takes it
   task automatic send_cell(bit x);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= req_data_type'(x);
      do @(posedge clock); while (!req_tready);
      board.note_cell(x);
   endtask

   // leaves csr_valid high; the caller drops it after the last beat
   task automatic write_csr(csr_index_type idx, csr_data_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
   endtask

   // cells of the top row cause no beat, so wait DrainCycles more after the queue empties
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(csr_data_type w, csr_data_type h, csr_data_type t);
      wait_idle();
      write_csr(casp_pkg::CsrMapWidth, w);
      write_csr(casp_pkg::CsrMapHeight, h);
      write_csr(casp_pkg::CsrThreshold, t);
      csr_valid <= 1'b0;
   endtask

   // Streams random cells until the map wraps. At beat shrink_at the size is cut down
   // mid-map; only shrinking is safe, growing would read line entries never written.
   task automatic send_map(int density, int shrink_at, csr_data_type shrink_w,
                           csr_data_type shrink_h, output int sent);
      int k;
      k = 0;
      do begin
         if (k == shrink_at) begin
            wait_idle();
            write_csr(casp_pkg::CsrMapWidth, shrink_w);
            write_csr(casp_pkg::CsrMapHeight, shrink_h);
            csr_valid <= 1'b0;
         end
         send_cell($urandom_range(0, 99) < density);
         k++;
      end while (board.row_ctr != 0 || board.col_ctr != 0);
      sent = k;
   endtask

   // receiver: random ready pattern, plus one long hold once results are flowing
   initial begin : rsp_side
      int run, gap;
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (want_hold && !held && rsp_tvalid) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         run = pick_run();
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // result checking and the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_cell(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WatchdogLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
            $display("cellular_automaton_smoothing_pass_top regression: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int                  random_sent, sent, maps, density, shrink_at;
      csr_data_type        w, h, t;
      board = new();
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      want_hold    <= 1'b0;
      req_steady   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // threshold zero: the lone interior air cell of an all-air 3x3 turns solid
      configure(11'd3, 11'd3, 11'd0);
      repeat (9) send_cell(1'b0);
      // air centre ringed by eight solid cells meets a threshold of eight
      configure(11'd3, 11'd3, 11'd8);
      for (int i = 0; i < 9; i++) send_cell(i != 4);
      // write to an unmapped index, then threshold with junk in its upper bits
      wait_idle();
      write_csr(CsrUnmapped, 11'h7FF);
      csr_valid <= 1'b0;
      // single-cell map: every beat is a whole map and comes straight back
      configure(11'd1, 11'd1, 11'h7F5);
      send_cell(1'b0);
      send_cell(1'b1);

      // width saturates to the maximum, then is cut down while the column is far past
      // the new edge; receiver stalls once rows flow
      configure(11'd2047, 11'd2, 11'd3);
      want_hold <= 1'b1;
      req_steady = 1'b1;
      send_map(50, 30, 11'd12, 11'd2, sent);
      req_steady = 1'b0;
      // zero width saturates to one column, height to the maximum; cut down deep in the map
      configure(11'd0, 11'd2047, 11'd15);
      send_map(50, 20, 11'd1, 11'd3, sent);
      // zero height saturates to one row
      configure(11'd5, 11'd0, 11'd15);
      send_map(50, -1, '0, '0, sent);
      // threshold above eight: no air cell ever turns solid
      configure(11'd6, 11'd5, 11'd15);
      send_map(70, -1, '0, '0, sent);

      random_sent = 0;
      maps = 0;
      while (random_sent < RandomCells) begin
         case ($urandom_range(0, 9))
            0, 1:    w = csr_data_type'($urandom_range(1, 2));
            2:       w = csr_data_type'($urandom_range(13, 40));
            default: w = csr_data_type'($urandom_range(3, 12));
         endcase
         h = ($urandom_range(0, 7) == 0) ? csr_data_type'($urandom_range(1, 2))
                                         : csr_data_type'($urandom_range(3, 8));
         t = ($urandom_range(0, 3) == 0) ? csr_data_type'($urandom_range(0, 15))
                                         : csr_data_type'($urandom_range(2, 7));
         case ($urandom_range(0, 9))
            0:       density = 0;
            1:       density = 100;
            default: density = $urandom_range(5, 95);
         endcase
         shrink_at = -1;
         // first map is cut down part way through
         if (maps == 0) begin
            w = csr_data_type'($urandom_range(6, 12));
            h = csr_data_type'($urandom_range(4, 8));
            shrink_at = (int'(w) * int'(h)) / 2;
         end
         configure(w, h, t);
         req_steady = ($urandom_range(0, 4) == 0);
         send_map(density, shrink_at, csr_data_type'($urandom_range(1, w)),
                  csr_data_type'($urandom_range(1, h)), sent);
         random_sent += sent;
         maps++;
      end

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (board.pending() != 0)
         $display("%0t: %0d expected beats never arrived", $time, board.pending());
      if (board.errors == 0 && board.pending() == 0) begin
         $display("cellular_automaton_smoothing_pass_top regression: pass");
      end else begin
         $display("cellular_automaton_smoothing_pass_top regression: fail");
      end
      $finish;
   end

endmodule
